/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the share generator checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on clk, disabled while rst is low.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is low.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ssg_pkg.sv */
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants of the GF(2^8) share generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int MaxSharesDef    = 16;
  localparam int MaxThresholdDef = 16;
  localparam int QueueDepth      = 2;

  // Configuration register indexes
  localparam logic [1:0] CfgThreshold  = 2'd0;
  localparam logic [1:0] CfgShareCount = 2'd1;
  localparam logic [1:0] CfgFieldPoly  = 2'd2;

  localparam logic [4:0] ThresholdRst  = 5'd2;
  localparam logic [4:0] ShareCountRst = 5'd5;
  localparam logic [7:0] FieldPolyRst  = 8'h1b;

  // One classified coefficient on its way to the evaluator
  typedef struct packed {
    logic [7:0] coef;
    logic       close;
  } q_entry_t;

  // Settings the evaluator needs
  typedef struct packed {
    logic [4:0] share_count;
    logic [7:0] field_poly;
  } back_cfg_t;

endpackage

/* rtl/core/ssg_front.sv */
// ----------------------------------------------------------------------------
// ssg_front
// Accepts coefficients, tracks position in the group, marks the closing one.
// ----------------------------------------------------------------------------
module ssg_front #(
  parameter int MAX_THRESHOLD = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        coefficient_i,
  input  logic [4:0]        threshold_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output ssg_pkg::q_entry_t entry_o
);
  import ssg_pkg::*;

  localparam int PW = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    k8;
  logic [7:0]    next_pos8;
  logic          close;

  // Clamp threshold into 1..MAX_THRESHOLD
  always_comb begin
    if (threshold_i == 5'd0) begin
      k8 = 8'd1;
    end else if ({3'b000, threshold_i} > 8'(MAX_THRESHOLD)) begin
      k8 = 8'(MAX_THRESHOLD);
    end else begin
      k8 = {3'b000, threshold_i};
    end
  end

  assign next_pos8  = 8'(pos_q) + 8'd1;
  assign close      = (next_pos8 >= k8);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign entry_o.coef  = coefficient_i;
  assign entry_o.close = close;

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = close ? '0 : PW'(next_pos8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

/* rtl/core/ssg_queue.sv */
// ----------------------------------------------------------------------------
// ssg_queue
// Short FIFO of classified coefficients between front and evaluator.
// ----------------------------------------------------------------------------
module ssg_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssg_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output ssg_pkg::q_entry_t head_o
);
  import ssg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t      slots_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/ssg_back.sv */
// ----------------------------------------------------------------------------
// ssg_back
// Evaluation lanes for every share point plus the share drain register.
// ----------------------------------------------------------------------------
module ssg_back #(
  parameter int MAX_SHARES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssg_pkg::back_cfg_t cfg_i,
  input  logic               head_valid_i,
  input  ssg_pkg::q_entry_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         share_index_o,
  output logic [7:0]         share_value_o,
  output logic               last_share_o
);
  import ssg_pkg::*;

  localparam int SW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
  localparam int NW = $clog2(MAX_SHARES + 1);

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int bt = 0; bt < 8; bt++) begin
      if (b[bt]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ red) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  logic [7:0]    sums_q [MAX_SHARES];
  logic [7:0]    sums_d [MAX_SHARES];
  logic [7:0]    sums_nx [MAX_SHARES];
  logic [7:0]    pows_q [MAX_SHARES];
  logic [7:0]    pows_d [MAX_SHARES];
  logic [7:0]    pows_nx [MAX_SHARES];
  logic [7:0]    bank_q [MAX_SHARES];
  logic [7:0]    bank_d [MAX_SHARES];
  logic          busy_q, busy_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] n_clamp;
  logic [7:0]    idx8;
  logic          last_w, out_fire, can_load, load;

  // Clamp share count into 1..MAX_SHARES
  always_comb begin
    if (cfg_i.share_count == 5'd0) begin
      n_clamp = NW'(1);
    end else if ({3'b000, cfg_i.share_count} > 8'(MAX_SHARES)) begin
      n_clamp = NW'(MAX_SHARES);
    end else begin
      n_clamp = NW'(cfg_i.share_count);
    end
  end

  assign idx8     = 8'(cnt_q) + 8'd1;
  assign last_w   = (idx8 == 8'(n_q));
  assign out_fire = busy_q && !out_stall_i;
  assign can_load = !busy_q || (out_fire && last_w);
  assign pop_o    = head_valid_i && (!head_i.close || can_load);
  assign load     = pop_o && head_i.close;

  // One multiply-accumulate and one power step per lane
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      sums_nx[i] = sums_q[i] ^ gf_mul(pows_q[i], head_i.coef, cfg_i.field_poly);
      pows_nx[i] = gf_mul(pows_q[i], 8'(i + 1), cfg_i.field_poly);
      sums_d[i]  = sums_q[i];
      pows_d[i]  = pows_q[i];
      if (pop_o) begin
        sums_d[i] = head_i.close ? 8'h00 : sums_nx[i];
        pows_d[i] = head_i.close ? 8'h01 : pows_nx[i];
      end
    end
  end

  // Drain: load the finished group, then shift one share out per transaction
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    for (int i = 0; i < MAX_SHARES; i++) begin
      bank_d[i] = bank_q[i];
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = n_clamp;
      for (int i = 0; i < MAX_SHARES; i++) begin
        bank_d[i] = sums_nx[i];
      end
    end else if (out_fire) begin
      if (last_w) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + SW'(1);
        for (int i = 0; i < MAX_SHARES - 1; i++) begin
          bank_d[i] = bank_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      bank_q[i] <= bank_d[i];
    end
    n_q <= n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      for (int i = 0; i < MAX_SHARES; i++) begin
        sums_q[i] <= 8'h00;
        pows_q[i] <= 8'h01;
      end
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      for (int i = 0; i < MAX_SHARES; i++) begin
        sums_q[i] <= sums_d[i];
        pows_q[i] <= pows_d[i];
      end
    end
  end

  assign out_valid_o   = busy_q;
  assign share_index_o = idx8[4:0];
  assign share_value_o = bank_q[0];
  assign last_share_o  = last_w;

endmodule

/* rtl/core/shamir_share_generator_gf256_core.sv */
// ----------------------------------------------------------------------------
// shamir_share_generator_gf256_core
// Shamir secret split over GF(2^8): coefficients in, shares out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | sink      | in_valid_i / in_stall_o | coefficient_i
//   out     | source    | out_valid_o/out_stall_i | share_index_o, share_value_o,
//           |           |                         | last_share_o
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One coefficient transaction per cycle enters while the 2-entry queue has
// room. A group of k coefficients drains as n share transactions, one per
// cycle from the single drain register unless the output stalls; the next
// group may close only while the drain is idle or in the cycle its last
// share leaves. Reset sets all sums to zero and all powers to one at once,
// with no clearing pass. A stall on the output holds the current share while
// the evaluator keeps taking coefficients of the next group.
// ----------------------------------------------------------------------------
module shamir_share_generator_gf256_core #(
  parameter int MAX_SHARES    = ssg_pkg::MaxSharesDef,
  parameter int MAX_THRESHOLD = ssg_pkg::MaxThresholdDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // coefficient channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] coefficient_i,
  // share channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] share_index_o,
  output logic [7:0] share_value_o,
  output logic       last_share_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import ssg_pkg::*;

  logic [4:0] threshold_q;
  logic [4:0] share_count_q;
  logic [7:0] field_poly_q;

  logic       push, pop, q_full, head_valid;
  q_entry_t   entry, head;
  back_cfg_t  back_cfg;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= ThresholdRst;
      share_count_q <= ShareCountRst;
      field_poly_q  <= FieldPolyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold:  threshold_q   <= cfg_wdata_i[4:0];
        CfgShareCount: share_count_q <= cfg_wdata_i[4:0];
        CfgFieldPoly:  field_poly_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign back_cfg.share_count = share_count_q;
  assign back_cfg.field_poly  = field_poly_q;

  // Front: accept and mark the coefficient that closes its group
  ssg_front #(
    .MAX_THRESHOLD(MAX_THRESHOLD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .coefficient_i(coefficient_i),
    .threshold_i  (threshold_q),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .entry_o      (entry)
  );

  // Queue: decouple intake from evaluation and drain
  ssg_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .pop_i       (pop),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // Back: accumulate every point, hand finished groups to the drain register
  ssg_back #(
    .MAX_SHARES(MAX_SHARES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (back_cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .share_index_o(share_index_o),
    .share_value_o(share_value_o),
    .last_share_o (last_share_o)
  );

endmodule

/* rtl/core/ssg_checker.sv */
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks on the share channel of the share generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] share_index_o,
  input logic [7:0] share_value_o,
  input logic       last_share_o
);

  logic out_fire;
  assign out_fire = out_valid_o && !out_stall_i;

  // Stalled share holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(share_value_o) && $stable(share_index_o) && $stable(last_share_o), "stalled share changed")

  // A group starts at point one
  `ASSERT_NXT(a_first_index, clk_i, rst_ni, out_fire && last_share_o, !out_valid_o || share_index_o == 5'd1, "group did not start at index one")

  // Shares of a group follow without gaps, in index order
  `ASSERT_NXT(a_next_index, clk_i, rst_ni, out_fire && !last_share_o, out_valid_o && share_index_o == $past(share_index_o) + 5'd1, "share sequence broken")

  // A last share never carries point zero
  `ASSERT_IMP(a_no_zero_index, clk_i, rst_ni, out_valid_o && last_share_o && share_index_o == 5'd0, 1'b0, "last share at index zero")

endmodule

bind shamir_share_generator_gf256_core ssg_checker u_ssg_checker (.*);
